// ===== design/kcs_pkg.sv =====
package kcs_pkg;

    // default number of keyframe slots
    localparam int KEYS_DEF = 64;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register indexes
    localparam logic [1:0] REG_KEY_COUNT   = 2'd0;
    localparam logic [1:0] REG_INTERP_MODE = 2'd1;
    localparam logic [1:0] REG_DURATION    = 2'd2;

    // interpolation codes
    localparam logic [1:0] INTERP_STEP   = 2'd0;
    localparam logic [1:0] INTERP_LINEAR = 2'd1;
    localparam logic [1:0] INTERP_CUBIC  = 2'd2;

    // item kinds carried in tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // stream widths
    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 56;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_CHK_LAST,
        S_SRCH,
        S_CMP,
        S_RD_K0,
        S_RD_K1,
        S_LD_K1,
        S_DIV,
        S_PRE,
        S_LMUL,
        S_LACC,
        S_F2,
        S_F3,
        S_M0,
        S_M1,
        S_HW,
        S_A0,
        S_A1,
        S_A2,
        S_A3,
        S_A4,
        S_A5,
        S_A6,
        S_DONE
    } t_state;

endpackage

// ===== design/keyframe_curve_sampler_core.sv =====
// Keyframe curve sampler for one scalar channel. A beat with tuser 0 stores a keyframe
// (time, value, in and out tangent) into its slot; a beat with tuser 1 evaluates the curve at
// the query time, clamped to the duration register, and returns one result beat with the
// sample value, the lower key index and the Q0.16 fraction. An evaluate first reads the first
// and last keys. A query strictly between them adds a binary search over the single read port
// of the key memory. The two bracketing keys are then read, and a bit-serial fraction divide
// follows when the bracket has a positive interval. Step mode then loads the result; linear
// mode adds a multiply and an accumulate, and cubic mode adds the Hermite steps, on the shared
// 34x33 multiplier. The block returns to idle before the next beat is taken, and it takes no
// new beat while an evaluate is in progress. A finished evaluate holds until the output
// register is free, but a beat may be taken while an earlier result still waits there.
module keyframe_curve_sampler_core #(
    parameter int KEYS = kcs_pkg::KEYS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input beat
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // tdata: key_index[5:0], key_time[37:6], key_value[69:38], in_tangent[101:70],
    //        out_tangent[133:102], query_time[165:134], zero pad[167:166]
    input  logic [kcs_pkg::S_DATA_W-1:0] s_tdata,
    // tuser: mode[0]
    input  logic                         s_tuser,
    // result beat
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // tdata: sample_value[31:0], lower_key[37:32], fraction[54:38], zero pad[55]
    output logic [kcs_pkg::M_DATA_W-1:0] m_tdata,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kcs_pkg::APB_AW-1:0]   paddr,
    input  logic [kcs_pkg::APB_DW-1:0]   pwdata,
    output logic [kcs_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import kcs_pkg::*;

    localparam int IW = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int NW = $clog2(KEYS + 1);
    localparam int CW = (NW > 7) ? NW : 7;
    localparam int XW = ((IW > 6) ? IW : 6) + 1;

    // input fields
    logic [5:0]         in_idx;
    logic [31:0]        in_time;
    logic signed [31:0] in_val;
    logic signed [31:0] in_tin;
    logic signed [31:0] in_tout;
    logic [31:0]        in_query;

    assign in_idx   = s_tdata[5:0];
    assign in_time  = s_tdata[37:6];
    assign in_val   = $signed(s_tdata[69:38]);
    assign in_tin   = $signed(s_tdata[101:70]);
    assign in_tout  = $signed(s_tdata[133:102]);
    assign in_query = s_tdata[165:134];

    // configuration registers
    logic [6:0]  r_key_count;
    logic [1:0]  r_interp;
    logic [31:0] r_duration;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= 7'd1;
            r_interp    <= INTERP_LINEAR;
            r_duration  <= 32'hFFFF_FFFF;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_KEY_COUNT:   r_key_count <= pwdata[6:0];
                REG_INTERP_MODE: r_interp    <= pwdata[1:0];
                REG_DURATION:    r_duration  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_KEY_COUNT:   prdata = {25'd0, r_key_count};
            REG_INTERP_MODE: prdata = {30'd0, r_interp};
            REG_DURATION:    prdata = r_duration;
            default:         prdata = '0;
        endcase
    end

    // clamp key count into 1..KEYS
    logic [CW-1:0] kc_ext;
    logic [NW-1:0] num_keys;
    logic [IW-1:0] last_idx;

    assign kc_ext = CW'(r_key_count);

    always_comb begin
        if (kc_ext == '0) begin
            num_keys = NW'(1);
        end else if (kc_ext > CW'(KEYS)) begin
            num_keys = NW'(KEYS);
        end else begin
            num_keys = NW'(kc_ext);
        end
    end

    assign last_idx = IW'(num_keys - NW'(1));

    // handshake
    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   s_acc;
    logic   out_free;

    assign s_tready = (r_state == S_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign out_free = ~r_ovalid | m_tready;
    assign m_tvalid = r_ovalid;

    // key memory: write slot, one read address shared by all four arrays
    logic [XW-1:0]      wr_idx_x;
    logic               wr_en;
    logic [IW-1:0]      rd_addr;
    logic [31:0]        mem_time [KEYS];
    logic [31:0]        mem_val  [KEYS];
    logic [31:0]        mem_tin  [KEYS];
    logic [31:0]        mem_tout [KEYS];
    logic [31:0]        rd_time;
    logic signed [31:0] rd_val;
    logic signed [31:0] rd_tin;
    logic signed [31:0] rd_tout;
    logic [31:0]        rd_val_u;
    logic [31:0]        rd_tin_u;
    logic [31:0]        rd_tout_u;

    assign wr_idx_x = XW'(in_idx);
    assign wr_en    = s_acc & (s_tuser == MODE_WRITE) & (wr_idx_x < XW'(KEYS));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_time[wr_idx_x[IW-1:0]] <= in_time;
            mem_val[wr_idx_x[IW-1:0]]  <= in_val;
            mem_tin[wr_idx_x[IW-1:0]]  <= in_tin;
            mem_tout[wr_idx_x[IW-1:0]] <= in_tout;
        end
        rd_time   <= mem_time[rd_addr];
        rd_val_u  <= mem_val[rd_addr];
        rd_tin_u  <= mem_tin[rd_addr];
        rd_tout_u <= mem_tout[rd_addr];
    end

    assign rd_val  = $signed(rd_val_u);
    assign rd_tin  = $signed(rd_tin_u);
    assign rd_tout = $signed(rd_tout_u);

    // datapath registers
    logic [31:0]        r_t, n_t;
    logic               r_le0, n_le0;
    logic               r_dofrac, n_dofrac;
    logic [IW-1:0]      r_lo, n_lo;
    logic [IW-1:0]      r_hi, n_hi;
    logic [IW-1:0]      r_mid, n_mid;
    logic [IW-1:0]      r_i0, n_i0;
    logic [IW-1:0]      r_i1, n_i1;
    logic [31:0]        r_t0, n_t0;
    logic [31:0]        r_t1, n_t1;
    logic signed [31:0] r_v0, n_v0;
    logic signed [31:0] r_v1, n_v1;
    logic signed [31:0] r_out0, n_out0;
    logic signed [31:0] r_in1, n_in1;
    logic [31:0]        r_rem, n_rem;
    logic [31:0]        r_div, n_div;
    logic [15:0]        r_q, n_q;
    logic [3:0]         r_cnt, n_cnt;
    logic [16:0]        r_frac, n_frac;
    logic [31:0]        r_f2, n_f2;
    logic [47:0]        r_f3, n_f3;
    logic signed [31:0] r_m0h, n_m0h;
    logic [15:0]        r_m0l, n_m0l;
    logic signed [31:0] r_m1h, n_m1h;
    logic [15:0]        r_m1l, n_m1l;
    logic signed [17:0] r_h00, n_h00;
    logic signed [17:0] r_h10, n_h10;
    logic signed [17:0] r_h01, n_h01;
    logic signed [17:0] r_h11, n_h11;
    logic signed [67:0] r_acc, n_acc;
    logic signed [66:0] r_prod;
    logic [M_DATA_W-1:0] r_mdata, n_mdata;

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] mul_p;

    assign mul_p = mul_a * mul_b;

    // search helpers
    logic [IW:0]   lo_p1;
    logic [IW:0]   mid_sum;
    logic [NW-1:0] i0_p1;

    assign lo_p1   = {1'b0, r_lo} + (IW+1)'(1);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign i0_p1   = NW'(r_i0) + NW'(1);

    // divider step
    logic [32:0] rem2;
    logic [32:0] rem_diff;
    logic        rem_ge;

    assign rem2     = {r_rem, 1'b0};
    assign rem_diff = rem2 - {1'b0, r_div};
    assign rem_ge   = (rem2 >= {1'b0, r_div});

    // interval and value deltas
    logic signed [32:0] dt;
    logic signed [32:0] dv;

    assign dt = $signed({1'b0, r_t1}) - $signed({1'b0, r_t0});
    assign dv = 33'(r_v1) - 33'(r_v0);

    // Hermite basis weights in Q48, floored to Q16
    logic signed [51:0] s_f3;
    logic signed [51:0] s_f2s;
    logic signed [51:0] s_f;
    logic signed [51:0] s_one;
    logic signed [51:0] w00;
    logic signed [51:0] w10;
    logic signed [51:0] w01;
    logic signed [51:0] w11;

    assign s_f3  = $signed({4'd0, r_f3});
    assign s_f2s = $signed({4'd0, r_f2, 16'd0});
    assign s_f   = $signed({3'd0, r_frac, 32'd0});
    assign s_one = $signed({3'd0, 1'b1, 48'd0});
    assign w00   = (s_f3 <<< 1) - s_f2s - (s_f2s <<< 1) + s_one;
    assign w10   = s_f3 - (s_f2s <<< 1) + s_f;
    assign w01   = s_f2s + (s_f2s <<< 1) - (s_f3 <<< 1);
    assign w11   = s_f3 - s_f2s;

    // product as an accumulator term
    logic signed [67:0] prod_x;

    assign prod_x = 68'(r_prod);

    // saturate the final sum
    logic signed [51:0] acc_q;
    logic signed [31:0] sat_val;
    logic [XW-1:0]      i0_x;

    assign acc_q = r_acc[67:16];
    assign i0_x  = XW'(r_i0);

    always_comb begin
        if (acc_q > 52'sd2147483647) begin
            sat_val = 32'sh7FFF_FFFF;
        end else if (acc_q < -52'sd2147483648) begin
            sat_val = 32'sh8000_0000;
        end else begin
            sat_val = acc_q[31:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && s_tuser == MODE_EVAL) begin
                    n_state = S_RD_FIRST;
                end
            end
            S_RD_FIRST: n_state = S_RD_LAST;
            S_RD_LAST:  n_state = S_CHK_LAST;
            S_CHK_LAST: begin
                if (r_le0 || r_t >= rd_time) begin
                    n_state = S_RD_K0;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (lo_p1 < {1'b0, r_hi}) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_RD_K0;
                end
            end
            S_CMP:   n_state = S_SRCH;
            S_RD_K0: n_state = S_RD_K1;
            S_RD_K1: n_state = S_LD_K1;
            S_LD_K1: begin
                if (r_dofrac && rd_time > r_t0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_PRE;
                end
            end
            S_DIV: begin
                if (r_cnt == 4'd15) begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                case (r_interp)
                    INTERP_LINEAR: n_state = S_LMUL;
                    INTERP_CUBIC:  n_state = S_F2;
                    default:       n_state = S_DONE;
                endcase
            end
            S_LMUL: n_state = S_LACC;
            S_LACC: n_state = S_DONE;
            S_F2:   n_state = S_F3;
            S_F3:   n_state = S_M0;
            S_M0:   n_state = S_M1;
            S_M1:   n_state = S_HW;
            S_HW:   n_state = S_A0;
            S_A0:   n_state = S_A1;
            S_A1:   n_state = S_A2;
            S_A2:   n_state = S_A3;
            S_A3:   n_state = S_A4;
            S_A4:   n_state = S_A5;
            S_A5:   n_state = S_A6;
            S_A6:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        n_t      = r_t;
        n_le0    = r_le0;
        n_dofrac = r_dofrac;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_i0     = r_i0;
        n_i1     = r_i1;
        n_t0     = r_t0;
        n_t1     = r_t1;
        n_v0     = r_v0;
        n_v1     = r_v1;
        n_out0   = r_out0;
        n_in1    = r_in1;
        n_rem    = r_rem;
        n_div    = r_div;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_frac   = r_frac;
        n_f2     = r_f2;
        n_f3     = r_f3;
        n_m0h    = r_m0h;
        n_m0l    = r_m0l;
        n_m1h    = r_m1h;
        n_m1l    = r_m1l;
        n_h00    = r_h00;
        n_h10    = r_h10;
        n_h01    = r_h01;
        n_h11    = r_h11;
        n_acc    = r_acc;
        n_mdata  = r_mdata;
        n_ovalid = r_ovalid & ~m_tready;
        rd_addr  = '0;
        mul_a    = '0;
        mul_b    = '0;

        unique case (r_state)
            S_IDLE: begin
                // clamp the query time
                n_t = (in_query > r_duration) ? r_duration : in_query;
            end
            S_RD_FIRST: rd_addr = '0;
            S_RD_LAST: begin
                rd_addr = last_idx;
                n_le0   = (r_t <= rd_time);
            end
            S_CHK_LAST: begin
                n_dofrac = 1'b0;
                if (r_le0) begin
                    n_i0 = '0;
                end else if (r_t >= rd_time) begin
                    n_i0 = last_idx;
                end else begin
                    n_lo     = '0;
                    n_hi     = last_idx;
                    n_dofrac = 1'b1;
                end
            end
            S_SRCH: begin
                if (lo_p1 < {1'b0, r_hi}) begin
                    rd_addr = mid_sum[IW:1];
                    n_mid   = mid_sum[IW:1];
                end else begin
                    n_i0 = r_lo;
                end
            end
            S_CMP: begin
                // narrow the bracket
                if (rd_time <= r_t) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = r_mid;
                end
            end
            S_RD_K0: begin
                rd_addr = r_i0;
                n_i1    = (i0_p1 < num_keys) ? IW'(i0_p1) : last_idx;
            end
            S_RD_K1: begin
                n_t0    = rd_time;
                n_v0    = rd_val;
                n_out0  = rd_tout;
                rd_addr = r_i1;
            end
            S_LD_K1: begin
                n_t1   = rd_time;
                n_v1   = rd_val;
                n_in1  = rd_tin;
                n_frac = '0;
                n_rem  = r_t - r_t0;
                n_div  = rd_time - r_t0;
                n_q    = '0;
                n_cnt  = '0;
            end
            S_DIV: begin
                // one quotient bit per cycle
                n_rem = rem_ge ? rem_diff[31:0] : rem2[31:0];
                n_q   = {r_q[14:0], rem_ge};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_frac = {1'b0, r_q[14:0], rem_ge};
                end
            end
            S_PRE: n_acc = 68'(r_v0) <<< 16;
            S_LMUL: begin
                mul_a = 34'(dv);
                mul_b = $signed({16'd0, r_frac});
            end
            S_LACC: n_acc = r_acc + prod_x;
            S_F2: begin
                mul_a = $signed({17'd0, r_frac});
                mul_b = $signed({16'd0, r_frac});
            end
            S_F3: begin
                n_f2  = r_prod[31:0];
                mul_a = $signed({2'd0, r_prod[31:0]});
                mul_b = $signed({16'd0, r_frac});
            end
            S_M0: begin
                n_f3  = r_prod[47:0];
                mul_a = 34'(dt);
                mul_b = 33'(r_out0);
            end
            S_M1: begin
                n_m0h = r_prod[63:32];
                n_m0l = r_prod[31:16];
                mul_a = 34'(dt);
                mul_b = 33'(r_in1);
            end
            S_HW: begin
                n_m1h = r_prod[63:32];
                n_m1l = r_prod[31:16];
                n_h00 = w00[49:32];
                n_h10 = w10[49:32];
                n_h01 = w01[49:32];
                n_h11 = w11[49:32];
                n_acc = '0;
            end
            S_A0: begin
                mul_a = 34'(r_v0);
                mul_b = 33'(r_h00);
            end
            S_A1: begin
                n_acc = r_acc + prod_x;
                mul_a = 34'(r_v1);
                mul_b = 33'(r_h01);
            end
            S_A2: begin
                n_acc = r_acc + prod_x;
                mul_a = 34'(r_m0h);
                mul_b = 33'(r_h10);
            end
            S_A3: begin
                n_acc = r_acc + (prod_x <<< 16);
                mul_a = $signed({18'd0, r_m0l});
                mul_b = 33'(r_h10);
            end
            S_A4: begin
                n_acc = r_acc + prod_x;
                mul_a = 34'(r_m1h);
                mul_b = 33'(r_h11);
            end
            S_A5: begin
                n_acc = r_acc + (prod_x <<< 16);
                mul_a = $signed({18'd0, r_m1l});
                mul_b = 33'(r_h11);
            end
            S_A6: n_acc = r_acc + prod_x;
            S_DONE: begin
                // load the result beat once the output register is free
                if (out_free) begin
                    n_mdata  = {1'b0, r_frac, i0_x[5:0], sat_val};
                    n_ovalid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_tdata = r_mdata;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_le0    <= n_le0;
        r_dofrac <= n_dofrac;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_i0     <= n_i0;
        r_i1     <= n_i1;
        r_t0     <= n_t0;
        r_t1     <= n_t1;
        r_v0     <= n_v0;
        r_v1     <= n_v1;
        r_out0   <= n_out0;
        r_in1    <= n_in1;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_q      <= n_q;
        r_cnt    <= n_cnt;
        r_frac   <= n_frac;
        r_f2     <= n_f2;
        r_f3     <= n_f3;
        r_m0h    <= n_m0h;
        r_m0l    <= n_m0l;
        r_m1h    <= n_m1h;
        r_m1l    <= n_m1l;
        r_h00    <= n_h00;
        r_h10    <= n_h10;
        r_h01    <= n_h01;
        r_h11    <= n_h11;
        r_acc    <= n_acc;
        r_prod   <= mul_p;
        r_mdata  <= n_mdata;
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import kcs_pkg::*;

    localparam int  NKEYS      = 64;
    localparam int  DRAIN_WAIT = 80;
    localparam int  CYCLE_CAP  = 800000;

    typedef struct {
        logic [31:0] value;
        logic [5:0]  lkey;
        logic [16:0] frac;
    } t_sample;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // shadow of the keyframe store and the registers
    longint unsigned trk_time [NKEYS];
    longint          trk_val  [NKEYS];
    longint          trk_tin  [NKEYS];
    longint          trk_tout [NKEYS];
    logic [6:0]      cfg_count;
    logic [1:0]      cfg_interp;
    logic [31:0]     cfg_dur;

    t_sample pending_samples[$];
    int      errors;
    int      cycles;
    bit      no_idle;
    int      stall_left;

    keyframe_curve_sampler_core DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("keyframe_curve_sampler_core: mismatch");
            $finish;
        end
    end

    task automatic report(string what, longint got, longint want);
        $display("ERROR %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic t_sample eval_curve(logic [31:0] q);
        int unsigned     n, i0, i1, lo, hi, mid;
        longint unsigned t, frac, dtu;
        longint          value, d, dt, m0, m1, f, f2, f3, h00, h10, h01, h11, acc;
        t_sample         r;
        n = cfg_count;
        if (n < 1) n = 1;
        if (n > NKEYS) n = NKEYS;
        t = q;
        if (t > cfg_dur) t = cfg_dur;
        frac = 0;
        if (t <= trk_time[0]) begin
            i0 = 0;
        end else if (t >= trk_time[n-1]) begin
            i0 = n - 1;
        end else begin
            lo = 0;
            hi = n - 1;
            while (lo + 1 < hi) begin
                mid = (lo + hi) / 2;
                if (trk_time[mid] <= t) lo = mid;
                else hi = mid;
            end
            i0 = lo;
            if (trk_time[i0+1] > trk_time[i0]) begin
                dtu  = trk_time[i0+1] - trk_time[i0];
                frac = ((t - trk_time[i0]) << 16) / dtu;
                if (frac > 65536) frac = 65536;
            end
        end
        i1 = (i0 + 1 < n) ? i0 + 1 : n - 1;
        if (cfg_interp == INTERP_LINEAR) begin
            d     = trk_val[i1] - trk_val[i0];
            value = trk_val[i0] + ((d * signed'(frac)) >>> 16);
        end else if (cfg_interp == INTERP_CUBIC) begin
            dt  = signed'(trk_time[i1]) - signed'(trk_time[i0]);
            m0  = (trk_tout[i0] * dt) >>> 16;
            m1  = (trk_tin[i1] * dt) >>> 16;
            f   = signed'(frac);
            f2  = f * f;
            f3  = f2 * f;
            h00 = (2 * f3 - 3 * f2 * 65536 + (64'sd1 <<< 48)) >>> 32;
            h10 = (f3 - 2 * f2 * 65536 + f * (64'sd1 <<< 32)) >>> 32;
            h01 = (-2 * f3 + 3 * f2 * 65536) >>> 32;
            h11 = (f3 - f2 * 65536) >>> 32;
            acc = trk_val[i0] * h00 + m0 * h10 + trk_val[i1] * h01 + m1 * h11;
            value = acc >>> 16;
        end else begin
            value = trk_val[i0];
        end
        if (value > 64'sd2147483647) value = 64'sd2147483647;
        if (value < -64'sd2147483648) value = -64'sd2147483648;
        r.value = value[31:0];
        r.lkey  = i0[5:0];
        r.frac  = frac[16:0];
        return r;
    endfunction

    // check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                report("unexpected result beat", longint'(m_tdata), 0);
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata[31:0] !== want.value)
                    report("sample_value", m_tdata[31:0], want.value);
                if (m_tdata[37:32] !== want.lkey)
                    report("lower_key", m_tdata[37:32], want.lkey);
                if (m_tdata[54:38] !== want.frac)
                    report("fraction", m_tdata[54:38], want.frac);
            end
        end
    end

    // stall the result side in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_tready   = 1'b0;
            stall_left = stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            m_tready   = 1'b0;
            stall_left = $urandom_range(0, 9);
        end else begin
            m_tready = 1'b1;
        end
    end

    // send one beat; predict on acceptance
    task automatic send_beat(logic mode, logic [5:0] idx, logic [31:0] kt, logic [31:0] kv,
                             logic [31:0] ti, logic [31:0] to, logic [31:0] q);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {2'b00, q, to, ti, kv, kt, idx};
        forever begin
            @(posedge i_clk);
            if (s_tready) break;
        end
        if (mode == MODE_WRITE) begin
            trk_time[idx] = kt;
            trk_val[idx]  = signed'(kv);
            trk_tin[idx]  = signed'(ti);
            trk_tout[idx] = signed'(to);
        end else begin
            pending_samples.push_back(eval_curve(q));
        end
        @(negedge i_clk);
    endtask

    task automatic write_key(int idx, logic [31:0] kt, logic [31:0] kv,
                             logic [31:0] ti, logic [31:0] to);
        send_beat(MODE_WRITE, idx[5:0], kt, kv, ti, to, $urandom);
    endtask

    task automatic evaluate(logic [31:0] q);
        send_beat(MODE_EVAL, 6'($urandom), $urandom, $urandom, $urandom, $urandom, q);
    endtask

    // hold input until every result is back, then let the block settle
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] regidx, logic [31:0] data);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {regidx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        case (regidx)
            REG_KEY_COUNT:   cfg_count  = data[6:0];
            REG_INTERP_MODE: cfg_interp = data[1:0];
            REG_DURATION:    cfg_dur    = data;
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(logic [6:0] cnt, logic [1:0] im, logic [31:0] dur);
        drain();
        reg_write(REG_KEY_COUNT, {25'd0, cnt});
        reg_write(REG_INTERP_MODE, {30'd0, im});
        reg_write(REG_DURATION, dur);
    endtask

    // extremes, zero interval, both ends and every mode on a short track
    task automatic test_directed();
        write_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        evaluate(32'h0000_0000);
        evaluate(32'hFFFF_FFFF);
        write_key(1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        write_key(2, 32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000);
        write_key(3, 32'h0003_0000, 32'h0005_8000, 32'h0000_0000, 32'h0002_0000);
        write_key(4, 32'h0004_8000, 32'hFFFA_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        write_key(5, 32'h0006_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        write_key(6, 32'h0008_0000, 32'h8000_0000, 32'h1234_5678, 32'hEDCB_A987);
        write_key(7, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        set_config(7'd8, INTERP_CUBIC, 32'hFFFF_FFFF);
        evaluate(32'h0000_0000);
        evaluate(32'h0001_8000);
        evaluate(32'h0002_0000);
        evaluate(32'h0002_8000);
        evaluate(32'h0005_0000);
        evaluate(32'hFFFF_FFFF);
        set_config(7'd8, INTERP_STEP, 32'h0004_0000);
        evaluate(32'h0005_0000);
        evaluate(32'h0001_4000);
        set_config(7'd8, INTERP_LINEAR, 32'h0000_0000);
        evaluate(32'h0003_8000);
        set_config(7'd8, 2'd3, 32'hFFFF_FFFF);
        evaluate(32'h0003_8000);
    endtask

    // load a full ascending track with random content
    task automatic load_track();
        logic [31:0] t;
        logic [31:0] step_max;
        t        = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hC000_0000)
                                               : $urandom_range(0, 4096);
        step_max = ($urandom_range(0, 1) == 0) ? 32'h0000_FFFF : 32'h00FF_FFFF;
        for (int k = 0; k < NKEYS; k++) begin
            write_key(k, t, $urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3FFFF),
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h3FFFF));
            if ($urandom_range(0, 7) != 0 && t < 32'hFE00_0000)
                t = t + $urandom_range(0, step_max);
        end
    endtask

    task automatic random_phase(int evals);
        int          sel;
        logic [31:0] lo_t, hi_t;
        lo_t = trk_time[0];
        hi_t = trk_time[NKEYS-1];
        for (int e = 0; e < evals; e++) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                // stray write, may leave the track out of order
                write_key($urandom_range(0, NKEYS - 1), $urandom, $urandom, $urandom, $urandom);
            end else if (sel < 3) begin
                evaluate($urandom);
            end else begin
                evaluate(lo_t + $urandom_range(0, (hi_t > lo_t) ? hi_t - lo_t + 2 : 2) - 1);
            end
        end
    endtask

    task automatic test_random();
        logic [6:0]  cnt;
        logic [31:0] dur;
        for (int p = 0; p < 12; p++) begin
            if (p >= 10) no_idle = 1'b1;
            if (p % 4 == 0) load_track();
            case (p % 6)
                0: cnt = 7'd64;
                1: cnt = 7'd0;
                2: cnt = 7'd127;
                3: cnt = 7'd1;
                default: cnt = $urandom_range(2, 100);
            endcase
            case ($urandom_range(0, 3))
                0: dur = 32'hFFFF_FFFF;
                1: dur = 32'd0;
                default: dur = $urandom;
            endcase
            set_config(cnt, p[1:0], dur);
            random_phase(125);
        end
    endtask

    initial begin
        errors     = 0;
        cycles     = 0;
        no_idle    = 1'b0;
        stall_left = 0;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tuser    = MODE_WRITE;
        s_tdata    = '0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_count  = 7'd1;
        cfg_interp = INTERP_LINEAR;
        cfg_dur    = 32'hFFFF_FFFF;
        for (int k = 0; k < NKEYS; k++) begin
            trk_time[k] = 0;
            trk_val[k]  = 0;
            trk_tin[k]  = 0;
            trk_tout[k] = 0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random();

        drain();
        if (errors == 0) begin
            $display("keyframe_curve_sampler_core: match");
        end else begin
            $display("keyframe_curve_sampler_core: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/kcs_pkg.sv
design/keyframe_curve_sampler_core.sv
test/tb_top.sv
